// ===== hdl/ultrasonic_median_range_alarm_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic median range alarm
// Clocked, reset-qualified property shorthands used by umra_checker.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_MEDIAN_RANGE_ALARM_MACROS_SVH
`define ULTRASONIC_MEDIAN_RANGE_ALARM_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define UMRA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define UMRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/umra_pkg.sv =====
// ----------------------------------------------------------------------------
// umra_pkg
// Constants, types and helper functions of the ultrasonic median range alarm.
// ----------------------------------------------------------------------------
`default_nettype none

package umra_pkg;

   // Block configuration
   localparam int CHANNELS    = 5;
   localparam int AUX_CHANNEL = 4;
   localparam int TIMEOUT_US  = 12000;

   // Field widths
   localparam int CH_W       = 3;
   localparam int WIDTH_W    = 14;
   localparam int DIST_W     = 10;
   localparam int PKG_W      = 6;
   localparam int RING_DEPTH = 3;
   localparam int POS_W      = 2;
   localparam int CSR_IDX_W  = 2;

   // Stream packing
   localparam int REQ_USED_W   = CH_W + WIDTH_W;
   localparam int REQ_TDATA_W  = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_DIST_LSB = CH_W;
   localparam int RSP_PKG_LSB  = CH_W + DIST_W;
   localparam int RSP_USED_W   = CH_W + DIST_W + PKG_W;
   localparam int RSP_TDATA_W  = ((RSP_USED_W + 7) / 8) * 8;

   // Distance constants
   localparam logic [DIST_W-1:0] NO_ECHO_CM = DIST_W'(999);
   // Largest real distance: a width right at the timeout, floor(12000 * 343 / 20000)
   localparam int MAX_ECHO_CM = 205;

   // Register reset values
   localparam logic [DIST_W-1:0] WIN_LOW_RST      = DIST_W'(2);
   localparam logic [DIST_W-1:0] WIN_HIGH_RST     = DIST_W'(60);
   localparam logic [DIST_W-1:0] WIN_HIGH_AUX_RST = DIST_W'(60);

   // floor(w * 343 / 20000) as (w * CM_RECIP) >> CM_SHIFT; exact for w < 2**14
   localparam int CM_SHIFT   = 29;
   localparam int CM_RECIP_W = 24;
   localparam longint unsigned CM_RECIP_FULL =
      (64'd343 * (64'd1 << CM_SHIFT) + 64'd19999) / 64'd20000;
   localparam logic [CM_RECIP_W-1:0] CM_RECIP = CM_RECIP_W'(CM_RECIP_FULL);
   localparam int PROD_W = WIDTH_W + CM_RECIP_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WIN_LOW      = 2'd0,
      REG_WIN_HIGH     = 2'd1,
      REG_WIN_HIGH_AUX = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [CH_W-1:0]   channel_out;
      logic [DIST_W-1:0] filtered_distance;
      logic              in_range;
      logic              round_done;
      logic [PKG_W-1:0]  package_res;
   } result_type;

   typedef struct packed {
      logic [DIST_W-1:0] win_low;
      logic [DIST_W-1:0] win_high;
      logic [DIST_W-1:0] win_high_aux;
   } window_type;

   function automatic logic [DIST_W-1:0] width_to_cm(input logic [WIDTH_W-1:0] w);
      logic [PROD_W-1:0] prod;
      logic [DIST_W-1:0] cm;
      prod = PROD_W'(w) * PROD_W'(CM_RECIP);
      if (w == '0 || int'(w) > TIMEOUT_US) begin
         cm = NO_ECHO_CM;
      end else begin
         cm = DIST_W'(prod >> CM_SHIFT);
      end
      return cm;
   endfunction

   function automatic logic [DIST_W-1:0] mid_of_three(input logic [DIST_W-1:0] x,
                                                      input logic [DIST_W-1:0] y,
                                                      input logic [DIST_W-1:0] z);
      logic [DIST_W-1:0] lo;
      logic [DIST_W-1:0] hi;
      logic [DIST_W-1:0] mid;
      lo = (x < y) ? x : y;
      hi = (x < y) ? y : x;
      if (z <= lo) begin
         mid = lo;
      end else if (z >= hi) begin
         mid = hi;
      end else begin
         mid = z;
      end
      return mid;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ultrasonic_median_range_alarm.sv =====
// Ultrasonic median range alarm.
// Each transfer on the req_ channel carries one echo width (microseconds) for
// one sensor channel. The block converts it to centimeters (999 for no echo or
// a width above the timeout), pushes it into that channel's three-entry ring,
// and returns one rsp_ transfer with the median, an in-window flag in tuser,
// and on the last channel of a round the collected package word with tlast set.
// Items for a channel number past the last channel are taken and dropped.
// The req_ transfer loads the input register, which then moves on into the
// result register that drives rsp_tvalid. Throughput: one item per cycle while
// the rsp_ side is not stalled; the ring read, conversion multiply, median and
// window test all fit between those two registers, and the ring write-back of
// an item is seen by the next one.
// A stalled rsp_ side holds the result register; the input register still
// takes one more item, then req_tready drops until the result moves on.
// Reset (synchronous, active high) fills every ring with 999, clears slot
// counters, round flags and both valid stages, and loads the window registers
// with start 2, end 60, auxiliary end 60. The csr_ port is always ready.
// ----------------------------------------------------------------------------
// ultrasonic_median_range_alarm
// Top level: stream handshake, window registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_median_range_alarm (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: channel [2:0], echo_width [16:3], zero fill above
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [umra_pkg::REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: channel_out [2:0], filtered_distance [12:3], package_res [18:13]
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [umra_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast,  // round_done
   output logic                                  rsp_tuser,  // in_range
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [umra_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [umra_pkg::DIST_W-1:0]      csr_data
);

   // Window registers
   umra_pkg::window_type window_ff;

   // Input register
   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   logic [umra_pkg::CH_W-1:0]      s1_channel_ff;
   logic [umra_pkg::WIDTH_W-1:0]   s1_width_ff;

   // Result register
   logic                           out_valid_ff;
   logic                           out_valid_in;
   umra_pkg::result_type           out_ff;
   umra_pkg::result_type           core_result;

   logic                           s1_advance;
   logic                           req_accept;
   logic [umra_pkg::CH_W-1:0]      req_channel;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff.win_low      <= umra_pkg::WIN_LOW_RST;
         window_ff.win_high     <= umra_pkg::WIN_HIGH_RST;
         window_ff.win_high_aux <= umra_pkg::WIN_HIGH_AUX_RST;
      end else if (csr_valid) begin
         unique case (umra_pkg::reg_index_type'(csr_index))
            umra_pkg::REG_WIN_LOW:      window_ff.win_low      <= csr_data;
            umra_pkg::REG_WIN_HIGH:     window_ff.win_high     <= csr_data;
            umra_pkg::REG_WIN_HIGH_AUX: window_ff.win_high_aux <= csr_data;
            default: ;  // drop writes to unused indexes
         endcase
      end
   end

   // Move the input register forward when the result register is free or
   // is being drained this cycle.
   assign s1_advance  = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_advance;
   assign req_accept  = req_tvalid && req_tready;
   assign req_channel = req_tdata[umra_pkg::CH_W-1:0];

   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_advance;
      if (req_accept) begin
         // out-of-range channels are consumed without a result
         s1_valid_in = (int'(req_channel) < umra_pkg::CHANNELS);
      end
      out_valid_in = out_valid_ff && !rsp_tready;
      if (s1_advance) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_channel_ff <= req_channel;
         s1_width_ff   <= req_tdata[umra_pkg::CH_W +: umra_pkg::WIDTH_W];
      end
      if (s1_advance) begin
         out_ff <= core_result;
      end
   end

   umra_core u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (s1_advance),
      .channel    (s1_channel_ff),
      .echo_width (s1_width_ff),
      .window     (window_ff),
      .result     (core_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_ff.round_done;
   assign rsp_tuser  = out_ff.in_range;
   assign rsp_tdata  = {{(umra_pkg::RSP_TDATA_W - umra_pkg::RSP_USED_W){1'b0}},
                        out_ff.package_res,
                        out_ff.filtered_distance,
                        out_ff.channel_out};

endmodule

`default_nettype wire

// ===== hdl/umra_core.sv =====
// ----------------------------------------------------------------------------
// umra_core
// Per-channel median rings, window test and round flag collection.
// ----------------------------------------------------------------------------
`default_nettype none

module umra_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic [umra_pkg::CH_W-1:0]    channel,
   input  wire logic [umra_pkg::WIDTH_W-1:0] echo_width,
   input  wire umra_pkg::window_type         window,
   output umra_pkg::result_type              result
);

   logic [umra_pkg::DIST_W-1:0] ring_ff [umra_pkg::CHANNELS][umra_pkg::RING_DEPTH];
   logic [umra_pkg::POS_W-1:0]  pos_ff  [umra_pkg::CHANNELS];
   logic [umra_pkg::PKG_W-1:0]  flags_ff;
   logic [umra_pkg::PKG_W-1:0]  flags_in;

   logic [umra_pkg::DIST_W-1:0] row_cur [umra_pkg::RING_DEPTH];
   logic [umra_pkg::DIST_W-1:0] row_in  [umra_pkg::RING_DEPTH];
   logic [umra_pkg::POS_W-1:0]  pos_cur;
   logic [umra_pkg::POS_W-1:0]  pos_in;
   logic [umra_pkg::DIST_W-1:0] dist_new;
   logic [umra_pkg::DIST_W-1:0] median;
   logic [umra_pkg::DIST_W-1:0] top;
   logic [umra_pkg::PKG_W-1:0]  chan_bit;
   logic [umra_pkg::PKG_W-1:0]  flags_hit;
   logic                        hit;
   logic                        last;

   // select the row of this channel
   always_comb begin
      pos_cur = '0;
      for (int r = 0; r < umra_pkg::RING_DEPTH; r++) begin
         row_cur[r] = umra_pkg::NO_ECHO_CM;
      end
      for (int c = 0; c < umra_pkg::CHANNELS; c++) begin
         if (int'(channel) == c) begin
            pos_cur = pos_ff[c];
            for (int r = 0; r < umra_pkg::RING_DEPTH; r++) begin
               row_cur[r] = ring_ff[c][r];
            end
         end
      end
   end

   always_comb begin
      dist_new = umra_pkg::width_to_cm(echo_width);
      for (int r = 0; r < umra_pkg::RING_DEPTH; r++) begin
         row_in[r] = (int'(pos_cur) == r) ? dist_new : row_cur[r];
      end
      // a stray slot code restarts the ring at slot 0
      if (int'(pos_cur) > umra_pkg::RING_DEPTH - 1) begin
         row_in[0] = dist_new;
      end
      pos_in = (int'(pos_cur) >= umra_pkg::RING_DEPTH - 1) ? '0 : pos_cur + 1'b1;
      median = umra_pkg::mid_of_three(row_in[0], row_in[1], row_in[2]);

      top  = (int'(channel) == umra_pkg::AUX_CHANNEL) ? window.win_high_aux
                                                      : window.win_high;
      hit  = (median > window.win_low) && (median < top);
      last = (int'(channel) == umra_pkg::CHANNELS - 1);

      // channels past the package width only raise the alarm bit
      chan_bit = '0;
      for (int c = 0; c < umra_pkg::PKG_W - 1; c++) begin
         if (int'(channel) == c) begin
            chan_bit[c+1] = 1'b1;
         end
      end
      flags_hit = flags_ff;
      if (hit) begin
         flags_hit = flags_ff | chan_bit | umra_pkg::PKG_W'(1);
      end
      flags_in = last ? '0 : flags_hit;

      result.channel_out       = channel;
      result.filtered_distance = median;
      result.in_range          = hit;
      result.round_done        = last;
      result.package_res       = last ? flags_hit : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         for (int c = 0; c < umra_pkg::CHANNELS; c++) begin
            pos_ff[c] <= '0;
            for (int r = 0; r < umra_pkg::RING_DEPTH; r++) begin
               ring_ff[c][r] <= umra_pkg::NO_ECHO_CM;
            end
         end
      end else if (advance) begin
         flags_ff <= flags_in;
         for (int c = 0; c < umra_pkg::CHANNELS; c++) begin
            if (int'(channel) == c) begin
               pos_ff[c] <= pos_in;
               for (int r = 0; r < umra_pkg::RING_DEPTH; r++) begin
                  ring_ff[c][r] <= row_in[r];
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== hdl/umra_checker.sv =====
// ----------------------------------------------------------------------------
// umra_checker
// Port-level checks on the result stream of the ultrasonic median range alarm.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ultrasonic_median_range_alarm_macros.svh"

module umra_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [umra_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic                             rsp_tlast,
   input wire logic                             rsp_tuser
);

   logic [umra_pkg::CH_W-1:0]   rsp_channel;
   logic [umra_pkg::DIST_W-1:0] rsp_dist;
   logic [umra_pkg::PKG_W-1:0]  rsp_pkg;
   logic                        stalled;
   logic                        dist_legal;
   logic                        last_is_top;

   assign rsp_channel = rsp_tdata[umra_pkg::CH_W-1:0];
   assign rsp_dist    = rsp_tdata[umra_pkg::RSP_DIST_LSB +: umra_pkg::DIST_W];
   assign rsp_pkg     = rsp_tdata[umra_pkg::RSP_PKG_LSB +: umra_pkg::PKG_W];
   assign stalled     = rsp_tvalid && !rsp_tready;
   assign dist_legal  = (int'(rsp_dist) <= umra_pkg::MAX_ECHO_CM) ||
                        (rsp_dist == umra_pkg::NO_ECHO_CM);
   assign last_is_top = (int'(rsp_channel) == umra_pkg::CHANNELS - 1);

   // hold a stalled result
   `UMRA_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser), "rsp payload changed while stalled")
   // package word is only shown at the end of a round
   `UMRA_ASSERT_NOW(a_pkg_only_last, clock, reset, rsp_tvalid && !rsp_tlast, rsp_pkg == '0, "package word set outside round end")
   // round end belongs to the last channel and nothing else
   `UMRA_ASSERT_NOW(a_last_channel, clock, reset, rsp_tvalid, rsp_tlast == last_is_top, "round end flag on wrong channel")
   // median comes from the ring, so it is a real distance or the no-echo code
   `UMRA_ASSERT_NOW(a_dist_legal, clock, reset, rsp_tvalid, dist_legal, "filtered distance out of range")

endmodule

bind ultrasonic_median_range_alarm umra_checker u_umra_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== dv/ultrasonic_median_range_alarm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_median_range_alarm_checker
// Watches the req_, rsp_ and csr_ channels of the range alarm. Keeps its own
// per-channel distance rings, round flags and detection window, predicts one
// result per accepted echo on an existing channel and checks each rsp_ transfer field by field.
// ----------------------------------------------------------------------------
module ultrasonic_median_range_alarm_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [umra_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [umra_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   input  logic                                 rsp_tlast,
   input  logic                                 rsp_tuser,
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [umra_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [umra_pkg::DIST_W-1:0]          csr_data,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   result_count,
   output int                                   hit_count,
   output int                                   round_count
);

   umra_pkg::result_type        awaited_results[$];
   umra_pkg::window_type        window;
   logic [umra_pkg::DIST_W-1:0] dist_ring [umra_pkg::CHANNELS][umra_pkg::RING_DEPTH];
   logic [umra_pkg::POS_W-1:0]  ring_slot [umra_pkg::CHANNELS];
   logic [umra_pkg::PKG_W-1:0]  alarm_flags;

   assign pending = awaited_results.size();

   function automatic logic [umra_pkg::DIST_W-1:0] echo_to_cm(
         input logic [umra_pkg::WIDTH_W-1:0] w);
      int unsigned scaled;
      scaled = int'(w) * 343;
      if (w == '0 || int'(w) > umra_pkg::TIMEOUT_US) begin
         return umra_pkg::NO_ECHO_CM;
      end
      return umra_pkg::DIST_W'(scaled / 20000);
   endfunction

   // median = max(min(a, b), min(max(a, b), c))
   function automatic logic [umra_pkg::DIST_W-1:0] median3(
         input logic [umra_pkg::DIST_W-1:0] a,
         input logic [umra_pkg::DIST_W-1:0] b,
         input logic [umra_pkg::DIST_W-1:0] c);
      logic [umra_pkg::DIST_W-1:0] lo_ab;
      logic [umra_pkg::DIST_W-1:0] hi_ab;
      logic [umra_pkg::DIST_W-1:0] cap;
      lo_ab = (a < b) ? a : b;
      hi_ab = (a < b) ? b : a;
      cap   = (hi_ab < c) ? hi_ab : c;
      return (lo_ab > cap) ? lo_ab : cap;
   endfunction

   task automatic predict_echo(input logic [umra_pkg::CH_W-1:0] ch,
                               input logic [umra_pkg::WIDTH_W-1:0] w);
      umra_pkg::result_type        res;
      logic [umra_pkg::DIST_W-1:0] med;
      logic [umra_pkg::DIST_W-1:0] ceiling;
      logic                        hit;
      // drop channels past the last one: no result, no state change
      if (int'(ch) >= umra_pkg::CHANNELS) begin
         return;
      end
      dist_ring[ch][ring_slot[ch]] = echo_to_cm(w);
      ring_slot[ch] = (int'(ring_slot[ch]) == umra_pkg::RING_DEPTH - 1) ? '0
                      : ring_slot[ch] + umra_pkg::POS_W'(1);
      med = median3(dist_ring[ch][0], dist_ring[ch][1], dist_ring[ch][2]);
      ceiling = (int'(ch) == umra_pkg::AUX_CHANNEL) ? window.win_high_aux
                                                    : window.win_high;
      hit = (med > window.win_low) && (med < ceiling);
      if (hit) begin
         alarm_flags[0] = 1'b1;
         if (int'(ch) + 1 < umra_pkg::PKG_W) begin
            alarm_flags[ch + umra_pkg::CH_W'(1)] = 1'b1;
         end
      end
      res.channel_out       = ch;
      res.filtered_distance = med;
      res.in_range          = hit;
      res.round_done        = (int'(ch) == umra_pkg::CHANNELS - 1);
      res.package_res       = '0;
      if (res.round_done) begin
         res.package_res = alarm_flags;
         alarm_flags     = '0;
      end
      awaited_results.push_back(res);
   endtask

   task automatic flag_field(input string name, input int exp_val, input int got_val);
      if (exp_val != got_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, got_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      umra_pkg::result_type got;
      umra_pkg::result_type want;
      if (reset) begin
         fail_count   = 0;
         result_count = 0;
         hit_count    = 0;
         round_count  = 0;
         awaited_results.delete();
         window.win_low      = umra_pkg::WIN_LOW_RST;
         window.win_high     = umra_pkg::WIN_HIGH_RST;
         window.win_high_aux = umra_pkg::WIN_HIGH_AUX_RST;
         for (int c = 0; c < umra_pkg::CHANNELS; c++) begin
            for (int k = 0; k < umra_pkg::RING_DEPTH; k++) begin
               dist_ring[c][k] = umra_pkg::NO_ECHO_CM;
            end
            ring_slot[c] = '0;
         end
         alarm_flags = '0;
      end else begin
         // compare the result transfer against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.channel_out       = rsp_tdata[umra_pkg::CH_W-1:0];
            got.filtered_distance = rsp_tdata[umra_pkg::RSP_DIST_LSB +: umra_pkg::DIST_W];
            got.in_range          = rsp_tuser;
            got.round_done        = rsp_tlast;
            got.package_res       = rsp_tdata[umra_pkg::RSP_PKG_LSB +: umra_pkg::PKG_W];
            if (awaited_results.size() == 0) begin
               $error("result transfer with nothing awaited: channel %0d distance %0d",
                      got.channel_out, got.filtered_distance);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               flag_field("channel_out", int'(want.channel_out), int'(got.channel_out));
               flag_field("filtered_distance", int'(want.filtered_distance),
                          int'(got.filtered_distance));
               flag_field("in_range", int'(want.in_range), int'(got.in_range));
               flag_field("round_done", int'(want.round_done), int'(got.round_done));
               flag_field("package_res", int'(want.package_res), int'(got.package_res));
               result_count++;
               hit_count   += int'(want.in_range);
               round_count += int'(want.round_done);
            end
         end
         if (req_tvalid && req_tready) begin
            predict_echo(req_tdata[umra_pkg::CH_W-1:0],
                         req_tdata[umra_pkg::CH_W +: umra_pkg::WIDTH_W]);
         end
         if (csr_valid && csr_ready) begin
            case (umra_pkg::reg_index_type'(csr_index))
               umra_pkg::REG_WIN_LOW:      window.win_low      = csr_data;
               umra_pkg::REG_WIN_HIGH:     window.win_high     = csr_data;
               umra_pkg::REG_WIN_HIGH_AUX: window.win_high_aux = csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== dv/ultrasonic_median_range_alarm_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_median_range_alarm_tb
// Drives echo widths into the range alarm through a directed set of edge
// cases and then random sensor rounds under several detection windows, with
// random idling on both streams and one long result-side hold-off. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module ultrasonic_median_range_alarm_tb;

   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLDOFF_CYCLES = 200;
   // settle time after the last awaited result; covers dropped items in flight
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_ITEMS = 210;
   // index with no register behind it; writes there must change nothing
   localparam logic [umra_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [umra_pkg::REQ_TDATA_W-1:0]     req_tdata = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [umra_pkg::RSP_TDATA_W-1:0]     rsp_tdata;
   logic                                 rsp_tlast;
   logic                                 rsp_tuser;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [umra_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [umra_pkg::DIST_W-1:0]          csr_data = '0;

   int fail_count;
   int pending;
   int result_count;
   int hit_count;
   int round_count;

   int echo_count = 0;
   int cycle_count = 0;
   bit req_gaps = 1'b1;   // sender idles at random while set
   bit rsp_gaps = 1'b1;   // receiver stalls at random while set
   bit holdoff_req = 1'b0;

   always #1 clock = ~clock;

   ultrasonic_median_range_alarm i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ultrasonic_median_range_alarm_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .result_count (result_count),
      .hit_count    (hit_count),
      .round_count  (round_count)
   );

   // Offer one echo transfer. Call and return at a falling edge; tvalid is
   // left high so back-to-back transfers need only one assignment per edge.
   task automatic push_echo(input logic [umra_pkg::CH_W-1:0] ch,
                            input logic [umra_pkg::WIDTH_W-1:0] w);
      while (req_gaps && $urandom_range(99) < 21) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= umra_pkg::REQ_TDATA_W'({w, ch});
      do @(posedge clock); while (!req_tready);
      if (int'(ch) < umra_pkg::CHANNELS) begin
         echo_count++;
      end
      @(negedge clock);
   endtask

   // Write one register, then drop valid on the following edge.
   task automatic write_csr(input logic [umra_pkg::CSR_IDX_W-1:0] idx,
                            input logic [umra_pkg::DIST_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Hold until every awaited result is back, then let dropped items clear.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Mostly widths near the detection window, plus no-echo, timeout and
   // full-range values so every width bit toggles.
   function automatic logic [umra_pkg::WIDTH_W-1:0] pick_echo_width();
      case ($urandom_range(9))
         0:       return '0;
         1:       return umra_pkg::WIDTH_W'($urandom_range(16383));
         2:       return umra_pkg::WIDTH_W'($urandom_range(16383, umra_pkg::TIMEOUT_US + 1));
         3, 4, 5, 6: return umra_pkg::WIDTH_W'($urandom_range(4000));
         default: return umra_pkg::WIDTH_W'($urandom_range(umra_pkg::TIMEOUT_US));
      endcase
   endfunction

   // Complete sensor rounds with random content, some with a channel left
   // out, and some single items on any channel number as noise.
   task automatic run_rounds(input int quota, input bit with_holdoff);
      int start_count;
      int skip;
      start_count = echo_count;
      while (echo_count - start_count < quota) begin
         if (with_holdoff && echo_count - start_count >= 60) begin
            holdoff_req  = 1'b1;
            with_holdoff = 1'b0;
         end
         if ($urandom_range(9) == 0) begin
            push_echo(umra_pkg::CH_W'($urandom_range(7)), pick_echo_width());
         end else begin
            skip = ($urandom_range(9) == 0) ? $urandom_range(umra_pkg::CHANNELS - 1) : -1;
            for (int c = 0; c < umra_pkg::CHANNELS; c++) begin
               if (c != skip) begin
                  push_echo(umra_pkg::CH_W'(c), pick_echo_width());
               end
            end
         end
      end
   endtask

   // Receiver: random stalls, and one long hold-off on request so the block
   // fills up and stalls the sender.
   initial begin
      forever begin
         @(negedge clock);
         if (holdoff_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(negedge clock);
            holdoff_req = 1'b0;
         end else begin
            rsp_tready <= !(rsp_gaps && $urandom_range(99) < 21);
         end
      end
   end

   // Watchdog: fail the run if it has not finished within LIMIT_CYCLES.
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part under the reset window (start 2, end 60, aux end 60).
      push_echo(3'd0, 14'd0);        // no echo
      push_echo(3'd0, 14'd16383);    // all width bits set, above timeout
      push_echo(3'd0, 14'd12001);    // just above timeout
      push_echo(3'd0, 14'd12000);    // timeout itself still counts
      push_echo(3'd0, 14'd1);        // shortest echo, 0 cm
      push_echo(3'd0, 14'd117);      // 2 cm, on the lower window edge
      push_echo(3'd0, 14'd175);      // 3 cm, just inside
      push_echo(3'd0, 14'd175);
      push_echo(3'd1, 14'd3498);     // 59 cm, just inside the upper edge
      push_echo(3'd1, 14'd3499);     // 60 cm, on the upper edge
      push_echo(3'd1, 14'd3498);
      push_echo(3'd2, 14'd8191);
      push_echo(3'd3, 14'd10922);
      push_echo(3'd4, 14'd175);      // auxiliary channel, closes a round
      push_echo(3'd4, 14'd175);
      push_echo(3'd5, 14'd500);      // channel numbers past the last: dropped
      push_echo(3'd6, 14'd1000);
      push_echo(3'd7, 14'd16383);
      push_echo(3'd4, 14'd3499);     // round with only the aux channel
      push_echo(3'd3, 14'd0);        // rounds out of order
      push_echo(3'd2, 14'd5461);
      push_echo(3'd0, 14'd2000);
      push_echo(3'd4, 14'd2000);
      drain_results();

      // Widest window: even the no-echo code counts as detected.
      write_csr(umra_pkg::REG_WIN_LOW, 10'd0);
      write_csr(umra_pkg::REG_WIN_HIGH, 10'd1023);
      write_csr(umra_pkg::REG_WIN_HIGH_AUX, 10'd1023);
      run_rounds(PHASE_ITEMS, 1'b1);
      drain_results();

      // Empty window, and a stretch with no idling on either side.
      write_csr(umra_pkg::REG_WIN_LOW, 10'd1023);
      write_csr(umra_pkg::REG_WIN_HIGH, 10'd0);
      write_csr(umra_pkg::REG_WIN_HIGH_AUX, 10'd0);
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      run_rounds(PHASE_ITEMS, 1'b0);
      drain_results();
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;

      // Random window near the usable distances.
      write_csr(umra_pkg::REG_WIN_LOW, umra_pkg::DIST_W'($urandom_range(20)));
      write_csr(umra_pkg::REG_WIN_HIGH, umra_pkg::DIST_W'($urandom_range(120, 20)));
      write_csr(umra_pkg::REG_WIN_HIGH_AUX, umra_pkg::DIST_W'($urandom_range(300, 20)));
      run_rounds(PHASE_ITEMS, 1'b0);
      drain_results();

      // Aux window wide open, then a write to the unused index, which must
      // leave every register as it was.
      write_csr(umra_pkg::REG_WIN_LOW, umra_pkg::WIN_LOW_RST);
      write_csr(umra_pkg::REG_WIN_HIGH, umra_pkg::WIN_HIGH_RST);
      write_csr(umra_pkg::REG_WIN_HIGH_AUX, 10'd1023);
      write_csr(REG_UNUSED, umra_pkg::DIST_W'($urandom_range(1023)));
      run_rounds(PHASE_ITEMS, 1'b0);
      drain_results();

      $display("Covered %0d echo transfers in %0d cycles: %0d results checked,",
               echo_count, cycle_count, result_count);
      $display("%0d inside the window, %0d completed rounds, four window settings",
               hit_count, round_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/umra_pkg.sv
hdl/umra_core.sv
hdl/ultrasonic_median_range_alarm.sv
hdl/umra_checker.sv
dv/ultrasonic_median_range_alarm_checker.sv
dv/ultrasonic_median_range_alarm_tb.sv
